// File: hdl/fqp_pkg.sv
// ============================================================================
// fqp_pkg: shared types and constants of the FASTQ record parser
// Sizes, character codes, base tables and the command word that goes from
// the front end to the back end.
// ============================================================================
package fqp_pkg;

   // sizes
   localparam int MAX_LEN   = 1024;
   localparam int PHRED_MAX = 46;
   localparam int ADDR_W    = $clog2(MAX_LEN);
   localparam int CNT_W     = $clog2(MAX_LEN + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;

   // result kinds
   localparam logic [1:0] KIND_BASE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_PREMATURE_END = 3'd0;
   localparam logic [2:0] ERR_BAD_BASE      = 3'd1;
   localparam logic [2:0] ERR_PARSE         = 3'd2;
   localparam logic [2:0] ERR_NO_DATA       = 3'd3;
   localparam logic [2:0] ERR_QUAL_COUNT    = 3'd4;

   // command kinds from front to back
   localparam logic [1:0] CMD_STORE = 2'd0;
   localparam logic [1:0] CMD_BASE  = 2'd1;
   localparam logic [1:0] CMD_DONE  = 2'd2;
   localparam logic [1:0] CMD_ERROR = 2'd3;

   // configuration register map
   localparam logic REG_QUALITY_OFFSET = 1'b0;
   localparam logic [7:0] QUALITY_OFFSET_RESET = 8'd33;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] addr;
      logic [3:0]        code;
      logic [5:0]        quality;
      logic [CNT_W-1:0]  length;
      logic [2:0]        err;
   } cmd_type;

   // base tables, indexed by the low five bits of the letter
   localparam logic [3:0] TBL_FWD [32] = '{
      4'd0, 4'd1, 4'd14, 4'd2, 4'd13, 4'd0, 4'd0, 4'd4,
      4'd11, 4'd0, 4'd0, 4'd12, 4'd0, 4'd3, 4'd15, 4'd0,
      4'd0, 4'd0, 4'd5, 4'd6, 4'd8, 4'd8, 4'd7, 4'd9,
      4'd15, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
   localparam logic [3:0] TBL_REV [32] = '{
      4'd0, 4'd8, 4'd7, 4'd4, 4'd11, 4'd0, 4'd0, 4'd2,
      4'd13, 4'd0, 4'd0, 4'd3, 4'd0, 4'd12, 4'd15, 4'd0,
      4'd0, 4'd0, 4'd10, 4'd6, 4'd1, 4'd1, 4'd14, 4'd9,
      4'd15, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};

   function automatic logic [3:0] base_lookup(input logic [4:0] idx, input logic rev);
      base_lookup = rev ? TBL_REV[idx] : TBL_FWD[idx];
   endfunction

endpackage

// File: hdl/fqp_if.sv
// ============================================================================
// fqp_if: channel interfaces of the FASTQ record parser
// Valid/ready channels for the byte stream and for the results.
// ============================================================================
interface fqp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;
   logic       reverse_strand;

   modport source (output valid, data_byte, end_of_stream, reverse_strand, input ready);
   modport sink   (input valid, data_byte, end_of_stream, reverse_strand, output ready);
endinterface

interface fqp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [9:0]  position;
   logic [3:0]  base_code;
   logic [5:0]  quality_index;
   logic [10:0] record_length;
   logic [2:0]  error_code;

   modport source (output valid, result_kind, position, base_code, quality_index,
                   record_length, error_code, input ready);
   modport sink   (input valid, result_kind, position, base_code, quality_index,
                   record_length, error_code, output ready);
endinterface

// File: hdl/fastq_record_parser.sv
// Results pass the queue, stage one and the output stage. One byte per cycle while
// the queue has room; one command a cycle through the store port unless results
// stall. The four-entry command queue lets the parser run on while results stall.
// Reset (synchronous, active high) clears the parser, queue and output stage and
// sets quality_offset to 33; the base store is not cleared and needs no sweep.
// ============================================================================
// fastq_record_parser: FASTQ record body parser
// Parses sequence, separator and quality lines into base/quality beats.
// ============================================================================
module fastq_record_parser (
   input  logic         clock,
   input  logic         reset,
   fqp_req_if.sink      req_bus,
   fqp_rsp_if.source    rsp_bus,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [7:0]          qoffset_ff, qoffset_in;
   logic                q_full;
   logic                q_push;
   fqp_pkg::cmd_type    q_cmd;
   logic                q_pop;
   logic                q_head_valid;
   fqp_pkg::cmd_type    q_head_cmd;
   logic                csr_wr;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == fqp_pkg::REG_QUALITY_OFFSET);
   assign qoffset_in = csr_wr ? csr_pwdata[7:0] : qoffset_ff;
   assign csr_prdata = (csr_paddr[2] == fqp_pkg::REG_QUALITY_OFFSET) ?
                       {24'd0, qoffset_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         qoffset_ff <= fqp_pkg::QUALITY_OFFSET_RESET;
      end else begin
         qoffset_ff <= qoffset_in;
      end
   end

   fqp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .quality_offset (qoffset_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (q_cmd)
   );

   fqp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd)
   );

   fqp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd),
      .pop        (q_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: hdl/fqp_front.sv
// ============================================================================
// fqp_front: record parser front end
// Runs the line state machine on each byte beat and turns it into a
// command: store a base, emit a base with quality, complete or error.
// ============================================================================
module fqp_front (
   input  logic                 clock,
   input  logic                 reset,
   fqp_req_if.sink              req_bus,
   input  logic [7:0]           quality_offset,
   input  logic                 q_full,
   output logic                 q_push,
   output fqp_pkg::cmd_type     q_cmd
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_SEQ   = 3'd1;
   localparam logic [2:0] PH_SEP   = 3'd2;
   localparam logic [2:0] PH_PLUS  = 3'd3;
   localparam logic [2:0] PH_QSKIP = 3'd4;
   localparam logic [2:0] PH_QUAL  = 3'd5;

   logic [2:0]                 phase_ff, phase_in;
   logic [fqp_pkg::CNT_W-1:0]  bcount_ff, bcount_in;
   logic [fqp_pkg::CNT_W-1:0]  qcount_ff, qcount_in;
   logic                       strand_ff, strand_in;

   logic                       accept;
   logic                       has_cmd;
   fqp_pkg::cmd_type           cmd;
   logic [7:0]                 b;
   logic                       eol;
   logic [2:0]                 ph_eff;
   logic [fqp_pkg::CNT_W-1:0]  bc_eff;
   logic [fqp_pkg::CNT_W-1:0]  qc_eff;
   logic                       strand_eff;
   logic [3:0]                 code;
   logic [7:0]                 qdiff;
   logic [5:0]                 qval;
   logic                       qual_byte;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;
   assign eol           = (b == fqp_pkg::CHAR_LF) || (b == fqp_pkg::CHAR_CR);

   // a new record starts from clean counts and the current strand
   assign ph_eff     = (phase_ff == PH_IDLE) ? PH_SEQ : phase_ff;
   assign bc_eff     = (phase_ff == PH_IDLE) ? '0 : bcount_ff;
   assign qc_eff     = (phase_ff == PH_IDLE) ? '0 : qcount_ff;
   assign strand_eff = (phase_ff == PH_IDLE) ? req_bus.reverse_strand : strand_ff;

   assign code = fqp_pkg::base_lookup(b[4:0], strand_eff);

   // quality clamp to 0..PHRED_MAX
   assign qdiff = b - quality_offset;
   always_comb begin
      if (b < quality_offset) begin
         qval = '0;
      end else if (qdiff > 8'(fqp_pkg::PHRED_MAX)) begin
         qval = 6'(fqp_pkg::PHRED_MAX);
      end else begin
         qval = qdiff[5:0];
      end
   end

   // line state machine
   always_comb begin
      phase_in  = phase_ff;
      bcount_in = bcount_ff;
      qcount_in = qcount_ff;
      strand_in = strand_ff;
      has_cmd   = 1'b0;
      cmd       = '0;
      qual_byte = 1'b0;

      if (accept) begin
         if (phase_ff == PH_IDLE) begin
            strand_in = req_bus.reverse_strand;
            bcount_in = '0;
            qcount_in = '0;
            phase_in  = PH_SEQ;
         end

         if (req_bus.end_of_stream) begin
            has_cmd  = 1'b1;
            cmd.kind = fqp_pkg::CMD_ERROR;
            cmd.err  = (phase_ff == PH_QUAL) ? fqp_pkg::ERR_PARSE
                                             : fqp_pkg::ERR_PREMATURE_END;
         end else begin
            case (ph_eff)
               PH_SEQ: begin
                  if (eol) begin
                     if (bc_eff != '0) begin
                        phase_in = PH_SEP;
                     end
                  end else if (code == 4'd0) begin
                     has_cmd  = 1'b1;
                     cmd.kind = fqp_pkg::CMD_ERROR;
                     cmd.err  = fqp_pkg::ERR_BAD_BASE;
                  end else if (bc_eff >= fqp_pkg::CNT_W'(fqp_pkg::MAX_LEN - 1)) begin
                     has_cmd  = 1'b1;
                     cmd.kind = fqp_pkg::CMD_ERROR;
                     cmd.err  = fqp_pkg::ERR_PARSE;
                  end else begin
                     has_cmd   = 1'b1;
                     cmd.kind  = fqp_pkg::CMD_STORE;
                     cmd.addr  = bc_eff[fqp_pkg::ADDR_W-1:0];
                     cmd.code  = code;
                     bcount_in = bc_eff + 1'b1;
                  end
               end
               PH_SEP: begin
                  if (!eol) begin
                     if (b != fqp_pkg::CHAR_PLUS) begin
                        has_cmd  = 1'b1;
                        cmd.kind = fqp_pkg::CMD_ERROR;
                        cmd.err  = fqp_pkg::ERR_PARSE;
                     end else begin
                        phase_in = PH_PLUS;
                     end
                  end
               end
               PH_PLUS: begin
                  if (eol) begin
                     phase_in = PH_QSKIP;
                  end
               end
               PH_QSKIP: begin
                  if (!eol) begin
                     phase_in  = PH_QUAL;
                     qual_byte = 1'b1;
                  end
               end
               PH_QUAL: begin
                  if (eol) begin
                     has_cmd = 1'b1;
                     if (bc_eff == '0) begin
                        cmd.kind = fqp_pkg::CMD_ERROR;
                        cmd.err  = fqp_pkg::ERR_NO_DATA;
                     end else if (qc_eff != bc_eff) begin
                        cmd.kind = fqp_pkg::CMD_ERROR;
                        cmd.err  = fqp_pkg::ERR_QUAL_COUNT;
                     end else begin
                        cmd.kind   = fqp_pkg::CMD_DONE;
                        cmd.length = bc_eff;
                     end
                  end else begin
                     qual_byte = 1'b1;
                  end
               end
               default: begin
                  // unused phase codes fall back to the start
                  phase_in  = PH_IDLE;
                  bcount_in = '0;
                  qcount_in = '0;
               end
            endcase

            // quality byte paired with its stored base
            if (qual_byte) begin
               has_cmd = 1'b1;
               if (qc_eff >= bc_eff || qc_eff >= fqp_pkg::CNT_W'(fqp_pkg::MAX_LEN)) begin
                  cmd.kind = fqp_pkg::CMD_ERROR;
                  cmd.err  = fqp_pkg::ERR_QUAL_COUNT;
               end else begin
                  cmd.kind    = fqp_pkg::CMD_BASE;
                  cmd.addr    = qc_eff[fqp_pkg::ADDR_W-1:0];
                  cmd.quality = qval;
                  qcount_in   = qc_eff + 1'b1;
               end
            end
         end

         // errors and completion return to the start
         if (has_cmd && (cmd.kind == fqp_pkg::CMD_ERROR || cmd.kind == fqp_pkg::CMD_DONE)) begin
            phase_in  = PH_IDLE;
            bcount_in = '0;
            qcount_in = '0;
         end
      end
   end

   assign q_push = accept && has_cmd;
   assign q_cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         bcount_ff <= '0;
         qcount_ff <= '0;
         strand_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         bcount_ff <= bcount_in;
         qcount_ff <= qcount_in;
         strand_ff <= strand_in;
      end
   end

endmodule

// File: hdl/fqp_queue.sv
// ============================================================================
// fqp_queue: command queue between front and back end
// Small FIFO so that each side can stall on its own.
// ============================================================================
module fqp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fqp_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output fqp_pkg::cmd_type  head_cmd
);

   fqp_pkg::cmd_type               slot_ff [fqp_pkg::QUEUE_DEPTH];
   logic [fqp_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [fqp_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [fqp_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                           do_push;
   logic                           do_pop;

   assign full       = (count_ff == fqp_pkg::QCNT_W'(fqp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hdl/fqp_back.sv
// ============================================================================
// fqp_back: record parser back end
// Owns the base store, executes queued commands in order and drives the
// registered result beat.
// ============================================================================
module fqp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  fqp_pkg::cmd_type  head_cmd,
   output logic              pop,
   fqp_rsp_if.source         rsp_bus
);

   logic [3:0]          store_mem [fqp_pkg::MAX_LEN];
   logic [3:0]          rd_data_ff;

   logic                s1_valid_ff, s1_valid_in;
   fqp_pkg::cmd_type    s1_cmd_ff;

   logic                out_valid_ff, out_valid_in;
   logic [1:0]          out_kind_ff, out_kind_in;
   logic [9:0]          out_pos_ff, out_pos_in;
   logic [3:0]          out_code_ff, out_code_in;
   logic [5:0]          out_qual_ff, out_qual_in;
   logic [10:0]         out_len_ff, out_len_in;
   logic [2:0]          out_err_ff, out_err_in;

   logic                out_free;
   logic                s1_free;
   logic                s1_move;

   // handshake chain
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = head_valid && s1_free;
   assign s1_move  = s1_valid_ff && out_free;

   // base store: write on store commands, registered read otherwise
   always_ff @(posedge clock) begin
      if (pop) begin
         if (head_cmd.kind == fqp_pkg::CMD_STORE) begin
            store_mem[head_cmd.addr] <= head_cmd.code;
         end else begin
            rd_data_ff <= store_mem[head_cmd.addr];
         end
      end
   end

   // stage one holds the command alongside its store read
   assign s1_valid_in = pop ? (head_cmd.kind != fqp_pkg::CMD_STORE)
                            : (s1_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_cmd_ff <= head_cmd;
      end
   end

   // result formatting
   always_comb begin
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_pos_in   = out_pos_ff;
      out_code_in  = out_code_ff;
      out_qual_in  = out_qual_ff;
      out_len_in   = out_len_ff;
      out_err_in   = out_err_ff;
      if (s1_move) begin
         out_kind_in = fqp_pkg::KIND_ERROR;
         out_pos_in  = '0;
         out_code_in = '0;
         out_qual_in = '0;
         out_len_in  = '0;
         out_err_in  = '0;
         case (s1_cmd_ff.kind)
            fqp_pkg::CMD_BASE: begin
               out_kind_in = fqp_pkg::KIND_BASE;
               out_pos_in  = 10'(s1_cmd_ff.addr);
               out_code_in = rd_data_ff;
               out_qual_in = s1_cmd_ff.quality;
            end
            fqp_pkg::CMD_DONE: begin
               out_kind_in = fqp_pkg::KIND_DONE;
               out_len_in  = 11'(s1_cmd_ff.length);
            end
            default: begin
               out_kind_in = fqp_pkg::KIND_ERROR;
               out_err_in  = s1_cmd_ff.err;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_pos_ff  <= out_pos_in;
      out_code_ff <= out_code_in;
      out_qual_ff <= out_qual_in;
      out_len_ff  <= out_len_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.result_kind   = out_kind_ff;
   assign rsp_bus.position      = out_pos_ff;
   assign rsp_bus.base_code     = out_code_ff;
   assign rsp_bus.quality_index = out_qual_ff;
   assign rsp_bus.record_length = out_len_ff;
   assign rsp_bus.error_code    = out_err_ff;

endmodule
